>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the I2C byte engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

// Checked only while reset is released.
`define ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

>>> rtl/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Command codes and the item and result types shared by the engine modules.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  localparam logic [7:0] PhaseTicksReset = 8'd4;
  localparam logic [7:0] AckTimeoutReset = 8'd255;

  localparam logic RegPhaseTicks = 1'b0;
  localparam logic RegAckTimeout = 1'b1;

  localparam int InDataW  = 16;
  localparam int OutDataW = 16;

  typedef struct packed {
    op_e        op;
    logic [7:0] write_data;
    logic       give_ack;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic       ack_missing;
    logic [7:0] read_byte;
    logic       done_res;
    logic       ready_res;
    logic       sda_driven;
    logic       sda_level;
    logic       scl_level;
  } result_t;

endpackage

>>> rtl/i2cmbe_front.sv
// ----------------------------------------------------------------------------
// I2C byte engine front end
// Decodes the command of each tick item and buffers items in a short queue.
// ----------------------------------------------------------------------------
module i2cmbe_front import i2cmbe_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] command_i,
  input  logic [7:0] write_data_i,
  input  logic       give_ack_i,
  input  logic       sda_sample_i,
  output logic       q_valid_o,
  input  logic       q_pop_i,
  output item_t      q_item_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  item_t           mem_q [QueueDepth];
  item_t           item_in;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  always_comb begin
    item_in.write_data = write_data_i;
    item_in.give_ack   = give_ack_i;
    item_in.sda_sample = sda_sample_i;
    if ((command_i >= OP_START) && (command_i <= OP_READ)) begin
      item_in.op = op_e'(command_i);
    end else begin
      item_in.op = OP_IDLE;
    end
  end

  assign in_ready_o = (cnt_q != CntFull);
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

>>> rtl/i2cmbe_back.sv
// ----------------------------------------------------------------------------
// I2C byte engine back end
// Runs the bus phase sequencer one tick per item and registers each result.
// ----------------------------------------------------------------------------
module i2cmbe_back import i2cmbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] phase_ticks_i,
  input  logic [7:0] ack_timeout_i,
  input  logic       q_valid_i,
  output logic       q_pop_o,
  input  item_t      q_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    out_res_o
);

  localparam logic [3:0] PhEnd = 4'd15;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } line_t;

  typedef struct packed {
    op_e        op;
    logic [3:0] phase;
    logic [7:0] tick;
    logic [3:0] bitc;
    logic [7:0] shift;
    logic [7:0] poll;
    logic       ack_choice;
    line_t      ln;
    logic [7:0] read_hold;
    logic       miss_hold;
  } eng_t;

  eng_t       st_q, st_d;
  result_t    res_q, res_d;
  logic       out_valid_q, out_valid_d;
  logic       enter, done;
  logic [3:0] nph, nx;
  logic [7:0] span;

  function automatic line_t stop_lines(input logic [1:0] k, input line_t cur);
    line_t r;
    r = cur;
    unique case (k)
      2'd0: r.scl = 1'b0;
      2'd1: begin
        r.drv = 1'b1;
        r.sda = 1'b0;
      end
      2'd2: r.scl = 1'b1;
      default: begin
        r.drv = 1'b1;
        r.sda = 1'b1;
      end
    endcase
    return r;
  endfunction

  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign span        = (phase_ticks_i == 8'd0) ? 8'd1 : phase_ticks_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  always_comb begin
    st_d  = st_q;
    enter = 1'b0;
    nph   = 4'd0;
    nx    = PhEnd;
    done  = 1'b0;
    if (st_q.op == OP_IDLE) begin
      if (q_item_i.op != OP_IDLE) begin
        st_d.op   = q_item_i.op;
        st_d.bitc = 4'd0;
        if (q_item_i.op == OP_WRITE) begin
          st_d.shift     = q_item_i.write_data;
          st_d.miss_hold = 1'b0;
        end else if (q_item_i.op == OP_READ) begin
          st_d.shift      = 8'd0;
          st_d.ack_choice = q_item_i.give_ack;
        end
        enter = 1'b1;
      end
    end else if ((st_q.op == OP_WRITE) && (st_q.phase == 4'd4)) begin
      if (!q_item_i.sda_sample) begin
        enter = 1'b1;
        nph   = 4'd5;
      end else begin
        st_d.poll = st_q.poll - 8'd1;
        if (st_q.poll == 8'd1) begin
          st_d.miss_hold = 1'b1;
          enter          = 1'b1;
          nph            = 4'd6;
        end
      end
    end else if (st_q.tick < span) begin
      st_d.tick = st_q.tick + 8'd1;
    end else begin
      unique case (st_q.op)
        OP_START, OP_STOP: begin
          nx = (st_q.phase < 4'd3) ? st_q.phase + 4'd1 : PhEnd;
        end
        OP_WRITE: begin
          if (st_q.phase == 4'd1) begin
            st_d.bitc  = st_q.bitc + 4'd1;
            st_d.shift = {st_q.shift[6:0], 1'b0};
            nx         = (st_d.bitc < 4'd8) ? 4'd0 : 4'd2;
          end else if (st_q.phase == 4'd5) begin
            st_d.ln.drv = 1'b1;
          end else if (st_q.phase < 4'd9) begin
            nx = st_q.phase + 4'd1;
          end
        end
        OP_READ: begin
          if (st_q.phase == 4'd2) begin
            st_d.bitc = st_q.bitc + 4'd1;
            nx        = (st_d.bitc < 4'd8) ? 4'd1 : 4'd3;
          end else if (st_q.phase >= 4'd6) begin
            st_d.read_hold = st_q.shift;
          end else begin
            nx = st_q.phase + 4'd1;
          end
        end
        default: nx = PhEnd;
      endcase
      if (nx == PhEnd) begin
        st_d.op    = OP_IDLE;
        st_d.phase = 4'd0;
        st_d.tick  = 8'd0;
        st_d.bitc  = 4'd0;
        done       = 1'b1;
      end else begin
        enter = 1'b1;
        nph   = nx;
      end
    end

    if (enter) begin
      st_d.phase = nph;
      st_d.tick  = 8'd1;
      unique case (st_d.op)
        OP_START: begin
          unique case (nph)
            4'd0: begin
              st_d.ln.drv = 1'b1;
              st_d.ln.sda = 1'b1;
            end
            4'd1: st_d.ln.scl = 1'b1;
            4'd2: st_d.ln.sda = 1'b0;
            default: st_d.ln.scl = 1'b0;
          endcase
        end
        OP_STOP: st_d.ln = stop_lines(nph[1:0], st_d.ln);
        OP_WRITE: begin
          unique case (nph)
            4'd0: begin
              st_d.ln.scl = 1'b0;
              st_d.ln.sda = st_d.shift[7];
              st_d.ln.drv = 1'b1;
            end
            4'd1: st_d.ln.scl = 1'b1;
            4'd2: st_d.ln.scl = 1'b0;
            4'd3: begin
              st_d.ln.drv = 1'b0;
              st_d.ln.scl = 1'b1;
            end
            4'd4: st_d.poll = ack_timeout_i;
            4'd5: st_d.ln.scl = 1'b0;
            default: st_d.ln = stop_lines(2'(nph - 4'd6), st_d.ln);
          endcase
        end
        OP_READ: begin
          unique case (nph)
            4'd0: st_d.ln.drv = 1'b0;
            4'd1: st_d.ln.scl = 1'b0;
            4'd2: begin
              st_d.ln.scl = 1'b1;
              st_d.shift  = {st_d.shift[6:0], q_item_i.sda_sample};
            end
            4'd3: st_d.ln.scl = 1'b0;
            4'd4: begin
              st_d.ln.drv = 1'b1;
              st_d.ln.sda = !st_d.ack_choice;
            end
            4'd5: st_d.ln.scl = 1'b1;
            default: st_d.ln.scl = 1'b0;
          endcase
        end
        default: st_d.ln = st_d.ln;
      endcase
    end
  end

  always_comb begin
    res_d.scl_level   = st_d.ln.scl;
    res_d.sda_level   = st_d.ln.sda;
    res_d.sda_driven  = st_d.ln.drv;
    res_d.ready_res   = (st_d.op == OP_IDLE);
    res_d.done_res    = done;
    res_d.read_byte   = st_d.read_hold;
    res_d.ack_missing = st_d.miss_hold;
  end

  always_comb begin
    if (q_pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.op         <= OP_IDLE;
      st_q.phase      <= 4'd0;
      st_q.tick       <= 8'd0;
      st_q.bitc       <= 4'd0;
      st_q.shift      <= 8'd0;
      st_q.poll       <= 8'd0;
      st_q.ack_choice <= 1'b0;
      st_q.ln.scl     <= 1'b0;
      st_q.ln.sda     <= 1'b0;
      st_q.ln.drv     <= 1'b1;
      st_q.read_hold  <= 8'd0;
      st_q.miss_hold  <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (q_pop_o) begin
        st_q <= st_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

>>> rtl/i2c_master_byte_engine_unit.sv
// ----------------------------------------------------------------------------
// I2C master byte engine
// Tick-driven I2C master for start, stop, byte write and byte read commands.
// ----------------------------------------------------------------------------
// Each input transfer is one bus tick and yields exactly one result transfer
// showing SCL, SDA, the SDA drive enable and the command status after that
// tick. The engine takes one tick per clock cycle while results are taken; each
// result passes through the input queue and the result register of the phase
// sequencer. A result that waits holds the sequencer, and the two-entry input
// queue then takes further ticks until it is full.
// Commands are taken only while ready_res was high; others are ignored.
// Configuration is written through cfg_we_i.
module i2c_master_byte_engine_unit import i2cmbe_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // command[2:0], write_data[10:3], give_ack[11], sda_sample[12], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // scl_level[0], sda_level[1], sda_driven[2], ready_res[3], done_res[4],
  // read_byte[12:5], ack_missing[13], zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i
);

  logic [7:0] phase_ticks_q;
  logic [7:0] ack_timeout_q;
  logic       q_valid, q_pop;
  item_t      q_item;
  result_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PhaseTicksReset;
      ack_timeout_q <= AckTimeoutReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegPhaseTicks) begin
        phase_ticks_q <= cfg_wdata_i;
      end else begin
        ack_timeout_q <= cfg_wdata_i;
      end
    end
  end

  i2cmbe_front #(
    .QueueDepth(QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .command_i   (s_axis_tdata[2:0]),
    .write_data_i(s_axis_tdata[10:3]),
    .give_ack_i  (s_axis_tdata[11]),
    .sda_sample_i(s_axis_tdata[12]),
    .q_valid_o   (q_valid),
    .q_pop_i     (q_pop),
    .q_item_o    (q_item)
  );

  i2cmbe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .phase_ticks_i(phase_ticks_q),
    .ack_timeout_i(ack_timeout_q),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .q_item_i     (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_res_o    (res)
  );

  assign m_axis_tdata = {{(OutDataW - $bits(result_t)){1'b0}}, res};

endmodule

>>> rtl/i2cmbe_checker.sv
// ----------------------------------------------------------------------------
// I2C byte engine checker
// Port-level assertions on the result stream of the byte engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cmbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  logic out_stall;
  logic res_ready;
  logic res_done;
  logic res_driven;

  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign res_ready  = m_axis_tvalid && m_axis_tdata[3];
  assign res_done   = m_axis_tvalid && m_axis_tdata[4];
  assign res_driven = m_axis_tdata[2];

  `ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !m_axis_tvalid, "result after reset")

  `ASSERT_RUN(a_stall_holds, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "result moved")

  `ASSERT_RUN(a_done_is_ready, res_done |-> res_ready, "done without ready")

  `ASSERT_RUN(a_idle_drives_sda, res_ready |-> res_driven, "idle with SDA released")

endmodule

bind i2c_master_byte_engine_unit i2cmbe_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
